// ===== design/gia_pkg.sv =====
// ----------------------------------------------------------------------------
// gia_pkg: shared definitions for grid item auto-placement
// Field widths, line kind codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package gia_pkg;

	localparam int MAX_ROWS_DEF    = 64;
	localparam int MAX_COLUMNS_DEF = 16;

	localparam int CFG_W   = 5;
	localparam int KIND_W  = 2;
	localparam int VAL_W   = 8;
	localparam int ROW_OW  = 6;
	localparam int COL_OW  = 4;
	localparam int SPAN_OW = 5;
	localparam int CELL_OW = 11;

	typedef enum logic [KIND_W-1:0] {
		KIND_AUTO = 2'd0,
		KIND_LINE = 2'd1,
		KIND_SPAN = 2'd2
	} gia_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RESOLVE,
		ST_DIV,
		ST_READ,
		ST_CHECK,
		ST_WRITE,
		ST_END,
		ST_OUT
	} gia_state_t;

	typedef struct packed {
		logic load;
		logic resolve;
		logic div_step;
		logic rd_en;
		logic check;
		logic write;
		logic finish;
		logic load_out;
	} gia_cmd_t;

	typedef struct packed {
		logic has_start;
		logic cur_over;
		logic div_last;
		logic found;
		logic last_row;
		logic out_free;
	} gia_status_t;

endpackage

// ===== design/gia_item_if.sv =====
// ----------------------------------------------------------------------------
// gia_item_if: input channel of the grid placement block
// One word describes the start and end line of one grid item.
// ----------------------------------------------------------------------------
interface gia_item_if import gia_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic                    first_item;
	logic [KIND_W-1:0]       start_kind;
	logic signed [VAL_W-1:0] start_value;
	logic [KIND_W-1:0]       end_kind;
	logic signed [VAL_W-1:0] end_value;

	modport source (
		output valid, first_item, start_kind, start_value, end_kind, end_value,
		input  ready
	);

	modport sink (
		input  valid, first_item, start_kind, start_value, end_kind, end_value,
		output ready
	);

endinterface

// ===== design/gia_result_if.sv =====
// ----------------------------------------------------------------------------
// gia_result_if: result channel of the grid placement block
// One word carries the placed row, column, span, cell count and overflow.
// ----------------------------------------------------------------------------
interface gia_result_if import gia_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [ROW_OW-1:0]  row;
	logic [COL_OW-1:0]  column;
	logic [SPAN_OW-1:0] span;
	logic [CELL_OW-1:0] cells_used;
	logic               overflow;

	modport source (
		output valid, row, column, span, cells_used, overflow,
		input  ready
	);

	modport sink (
		input  valid, row, column, span, cells_used, overflow,
		output ready
	);

endinterface

// ===== design/gia_ram.sv =====
// ----------------------------------------------------------------------------
// gia_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module gia_ram import gia_pkg::*; #(
	parameter int WIDTH = MAX_COLUMNS_DEF,
	parameter int DEPTH = MAX_ROWS_DEF
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/gia_ctrl.sv =====
// ----------------------------------------------------------------------------
// gia_ctrl: sequencer for grid item placement
// Steps one item through resolve, cursor division, row search, update and
// result hand-off.
// ----------------------------------------------------------------------------
module gia_ctrl import gia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  gia_status_t status,
	output gia_cmd_t    cmd
);

	gia_state_t state_q;
	gia_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				cmd.resolve = 1'b1;
				if (status.has_start) begin
					state_n = ST_READ;
				end else if (status.cur_over) begin
					state_n = ST_OUT;
				end else begin
					state_n = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_n = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_n   = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (status.found) begin
					state_n = ST_WRITE;
				end else if (status.last_row) begin
					state_n = ST_OUT;
				end else begin
					state_n = ST_READ;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_n   = ST_END;
			end
			ST_END: begin
				cmd.finish = 1'b1;
				state_n    = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/gia_dp.sv =====
// ----------------------------------------------------------------------------
// gia_dp: datapath for grid item placement
// Line resolution, cursor divider, occupancy memory with row valid bits,
// free-run search within one row, placement update and the result register.
// ----------------------------------------------------------------------------
module gia_dp import gia_pkg::*; #(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CFG_W-1:0]        cfg_wr_data,
	input  logic                    first_item,
	input  logic [KIND_W-1:0]       start_kind,
	input  logic signed [VAL_W-1:0] start_value,
	input  logic [KIND_W-1:0]       end_kind,
	input  logic signed [VAL_W-1:0] end_value,
	input  logic                    res_ready,
	output logic                    res_valid,
	output logic [ROW_OW-1:0]       res_row,
	output logic [COL_OW-1:0]       res_column,
	output logic [SPAN_OW-1:0]      res_span,
	output logic [CELL_OW-1:0]      res_cells_used,
	output logic                    res_overflow,
	input  gia_cmd_t                cmd,
	output gia_status_t             status
);

	localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
	localparam int CIW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW     = $clog2(MAX_ROWS + 1);
	localparam int AW     = $clog2(MAX_ROWS);
	localparam int KW     = $clog2(RW);
	localparam int CELL_W = $clog2(MAX_ROWS * MAX_COLUMNS + 1);
	localparam int DW     = CELL_W + RW;
	localparam int SW     = COL_W + 9;
	localparam int MW1    = MAX_COLUMNS + 1;
	localparam int CW1    = COL_W + 1;

	localparam logic signed [SW-1:0] ONE_S  = 1;
	localparam logic signed [SW-1:0] ZERO_S = 0;

	logic [CFG_W-1:0]        colcnt_q;
	logic [COL_W-1:0]        cols;
	logic [KIND_W-1:0]       sk_q;
	logic [KIND_W-1:0]       ek_q;
	logic signed [VAL_W-1:0] sv_q;
	logic signed [VAL_W-1:0] ev_q;

	logic [MAX_ROWS-1:0] vld_q;
	logic [CELL_W-1:0]   cursor_q;
	logic [CELL_W-1:0]   hm_q;
	logic [CELL_W-1:0]   rem_q;
	logic [CELL_W-1:0]   rem_n;
	logic [CELL_W-1:0]   prod_q;
	logic [CELL_W-1:0]   end_c;
	logic [CELL_W-1:0]   lim_c;
	logic [RW-1:0]       quo_q;
	logic [RW-1:0]       quo_n;
	logic [RW-1:0]       row_q;
	logic [KW-1:0]       k_q;
	logic [DW-1:0]       dsub;

	logic [CIW-1:0]   start_q;
	logic [CIW-1:0]   col_q;
	logic [CIW-1:0]   pos;
	logic [COL_W-1:0] span_q;
	logic             auto_q;
	logic             ok_q;

	logic             has_start;
	logic [COL_W-1:0] start_c;
	logic [COL_W-1:0] span_c;

	logic [MAX_COLUMNS-1:0] ram_rdata;
	logic [MAX_COLUMNS-1:0] word;
	logic [MAX_COLUMNS-1:0] base;
	logic [MAX_COLUMNS-1:0] fit;
	logic [MAX_COLUMNS-1:0] wr_word;
	logic                   found;

	logic                   out_valid_q;
	logic [ROW_OW-1:0]      out_row_q;
	logic [COL_OW-1:0]      out_col_q;
	logic [SPAN_OW-1:0]     out_span_q;
	logic [CELL_OW-1:0]     out_cells_q;
	logic                   out_ovf_q;
	logic [RW-1:0]          row_sel;
	logic [CIW-1:0]         col_sel;

	// The column count register is clamped into 1..MAX_COLUMNS on use.
	always_comb begin
		if (colcnt_q == '0) begin
			cols = COL_W'(1);
		end else if (32'(colcnt_q) > MAX_COLUMNS) begin
			cols = COL_W'(MAX_COLUMNS);
		end else begin
			cols = COL_W'(colcnt_q);
		end
	end

	always_comb begin : resolve
		logic signed [SW-1:0] cols_s;
		logic signed [SW-1:0] sv_s;
		logic signed [SW-1:0] ev_s;
		logic signed [SW-1:0] raw_s;
		logic signed [SW-1:0] si_s;
		logic signed [SW-1:0] ei_s;
		logic                 hs;
		logic                 he;
		logic [COL_W-1:0]     s_c;
		logic [COL_W-1:0]     e_c;
		logic [COL_W-1:0]     cm1;
		cols_s = signed'(SW'(cols));
		sv_s   = SW'(sv_q);
		ev_s   = SW'(ev_q);
		raw_s  = ONE_S;
		if (sk_q == KIND_SPAN) begin
			raw_s = sv_s;
		end
		if (ek_q == KIND_SPAN) begin
			raw_s = ev_s;
		end
		if (raw_s < ZERO_S || raw_s > cols_s) begin
			span_c = cols;
		end else if (raw_s == ZERO_S) begin
			span_c = COL_W'(1);
		end else begin
			span_c = COL_W'(raw_s);
		end

		si_s = (sv_s > ZERO_S) ? sv_s - ONE_S : cols_s + ONE_S + sv_s;
		ei_s = (ev_s > ZERO_S) ? ev_s - ONE_S : cols_s + ONE_S + ev_s;
		hs   = (sk_q == KIND_LINE) && (si_s >= ZERO_S) && (si_s <= cols_s);
		he   = (ek_q == KIND_LINE) && (ei_s >= ZERO_S) && (ei_s <= cols_s);
		s_c  = COL_W'(si_s);
		e_c  = COL_W'(ei_s);
		cm1  = cols - COL_W'(1);

		has_start = 1'b0;
		start_c   = '0;
		if (hs && he && (e_c > s_c)) begin
			has_start = 1'b1;
			start_c   = (s_c < cm1) ? s_c : cm1;
			span_c    = e_c - s_c;
			if (span_c > cols - start_c) begin
				span_c = cols - start_c;
			end
		end else if (hs) begin
			has_start = 1'b1;
			start_c   = (s_c < cm1) ? s_c : cm1;
			if (span_c > cols - start_c) begin
				span_c = cols - start_c;
			end
		end else if (he) begin
			has_start = 1'b1;
			start_c   = (e_c >= span_c) ? e_c - span_c : '0;
			if (start_c > cols - span_c) begin
				start_c = cols - span_c;
			end
		end
	end

	// Restoring division of the cursor by the column count, one quotient bit
	// per cycle, most significant first.
	always_comb begin
		dsub  = DW'(cols) << k_q;
		rem_n = rem_q;
		quo_n = quo_q;
		if (DW'(rem_q) >= dsub) begin
			rem_n = rem_q - CELL_W'(dsub);
			quo_n = quo_q | (RW'(1) << k_q);
		end
	end

	assign lim_c = CELL_W'(cols) * CELL_W'(MAX_ROWS);

	always_comb begin : row_search
		logic [MW1-1:0] full;
		full = MW1'(1) << span_q;
		base = MAX_COLUMNS'(full - MW1'(1));
		word = vld_q[row_q[AW-1:0]] ? ram_rdata : '0;
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			fit[c] = (CW1'(c) + CW1'(span_q) <= CW1'(cols))
				&& (auto_q ? (CIW'(c) >= col_q) : (CIW'(c) == start_q))
				&& ((word & (base << c)) == '0);
		end
		found = |fit;
		pos   = '0;
		for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
			if (fit[c]) begin
				pos = CIW'(c);
			end
		end
		wr_word = word | (base << col_q);
	end

	assign end_c = prod_q + CELL_W'(col_q) + CELL_W'(span_q);

	gia_ram #(
		.WIDTH (MAX_COLUMNS),
		.DEPTH (MAX_ROWS)
	) u_occ (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (row_q[AW-1:0]),
		.wdata (wr_word),
		.re    (cmd.rd_en),
		.raddr (row_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colcnt_q    <= CFG_W'(1);
			vld_q       <= '0;
			cursor_q    <= '0;
			hm_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				colcnt_q <= cfg_wr_data;
			end
			if (cmd.load && first_item) begin
				vld_q    <= '0;
				cursor_q <= '0;
				hm_q     <= '0;
			end
			if (cmd.write) begin
				vld_q[row_q[AW-1:0]] <= 1'b1;
			end
			if (cmd.finish) begin
				if (end_c > hm_q) begin
					hm_q <= end_c;
				end
				if (auto_q) begin
					cursor_q <= end_c;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign row_sel = ok_q ? row_q : '0;
	assign col_sel = ok_q ? col_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sk_q <= start_kind;
			sv_q <= start_value;
			ek_q <= end_kind;
			ev_q <= end_value;
		end
		if (cmd.resolve) begin
			start_q <= CIW'(start_c);
			span_q  <= span_c;
			auto_q  <= !has_start;
			ok_q    <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			rem_q   <= cursor_q;
			quo_q   <= '0;
			k_q     <= KW'(RW - 1);
		end
		if (cmd.div_step) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
			k_q   <= k_q - KW'(1);
			if (k_q == '0) begin
				row_q <= quo_n;
				col_q <= CIW'(rem_n);
			end
		end
		if (cmd.check) begin
			if (found) begin
				ok_q  <= 1'b1;
				col_q <= pos;
			end else begin
				row_q <= row_q + RW'(1);
				col_q <= '0;
			end
		end
		if (cmd.write) begin
			prod_q <= CELL_W'(row_q) * CELL_W'(cols);
		end
		if (cmd.load_out) begin
			out_row_q   <= ROW_OW'(row_sel);
			out_col_q   <= COL_OW'(col_sel);
			out_span_q  <= SPAN_OW'(span_q);
			out_cells_q <= CELL_OW'(hm_q);
			out_ovf_q   <= !ok_q;
		end
	end

	assign status.has_start = has_start;
	assign status.cur_over  = (cursor_q >= lim_c);
	assign status.div_last  = (k_q == '0);
	assign status.found     = found;
	assign status.last_row  = (row_q == RW'(MAX_ROWS - 1));
	assign status.out_free  = !out_valid_q || res_ready;

	assign res_valid      = out_valid_q;
	assign res_row        = out_row_q;
	assign res_column     = out_col_q;
	assign res_span       = out_span_q;
	assign res_cells_used = out_cells_q;
	assign res_overflow   = out_ovf_q;

endmodule

// ===== design/grid_item_auto_placement.sv =====
// ----------------------------------------------------------------------------
// grid_item_auto_placement: places grid items into a column grid
// Each word on the item channel gives an item's start and end line as auto,
// a line index or a span; the block resolves them to a start column and a
// span, finds the first free run in the occupancy memory, marks it used and
// returns one word on the result channel with row, column, span, the highest
// used cell count and an overflow flag. first_item clears the grid first.
// The column count register may be written only while the block is idle.
// An item with a resolved start passes through resolve, then one memory read
// and one check per row read, then the update and the result hand-off; an auto
// item adds a bit-serial cursor division of clog2(MAX_ROWS+1) quotient bits, 7
// at 64 rows. One item is in work at a time: the next item is taken the cycle
// after the result enters the output register.
// Reset clears occupancy valid bits, cursor and cell count and sets the
// column count to 1; no clearing pass is needed. A stalled result holds in
// the output register while the next item is worked; its result waits to enter.
// ----------------------------------------------------------------------------
module grid_item_auto_placement import gia_pkg::*; #(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	gia_item_if.sink         item,
	gia_result_if.source     result
);

	gia_cmd_t    cmd;
	gia_status_t status;

	gia_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	gia_dp #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.first_item     (item.first_item),
		.start_kind     (item.start_kind),
		.start_value    (item.start_value),
		.end_kind       (item.end_kind),
		.end_value      (item.end_value),
		.res_ready      (result.ready),
		.res_valid      (result.valid),
		.res_row        (result.row),
		.res_column     (result.column),
		.res_span       (result.span),
		.res_cells_used (result.cells_used),
		.res_overflow   (result.overflow),
		.cmd            (cmd),
		.status         (status)
	);

endmodule

// ===== test/grid_item_auto_placement_tb.sv =====
// ----------------------------------------------------------------------------
// grid_item_auto_placement_tb: self-checking bench for grid item placement
// Drives item words through the item channel and compares every result word
// against a cycle-free model of the occupancy grid, the auto cursor and the
// cell high mark. A short directed pass covers the line, span and auto kinds
// and their corner cases; random phases then run several column settings,
// fill the grid to overflow and stall both channels at random.
// ----------------------------------------------------------------------------
module grid_item_auto_placement_tb import gia_pkg::*; ();

	localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

	typedef struct packed {
		logic                    first_item;
		logic [KIND_W-1:0]       start_kind;
		logic signed [VAL_W-1:0] start_value;
		logic [KIND_W-1:0]       end_kind;
		logic signed [VAL_W-1:0] end_value;
	} item_word_t;

	typedef struct packed {
		logic [ROW_OW-1:0]  row;
		logic [COL_OW-1:0]  column;
		logic [SPAN_OW-1:0] span;
		logic [CELL_OW-1:0] cells_used;
		logic               overflow;
	} result_word_t;

	class placement_board;
		logic [MAX_COLUMNS_DEF-1:0] occ [MAX_ROWS_DEF];
		int cursor;
		int high_mark;
		logic [CFG_W-1:0] column_reg;
		result_word_t placements_q[$];
		int errors;
		int checked;
		int overflows;

		function new();
			clear_grid();
			column_reg = 1;
			errors = 0;
			checked = 0;
			overflows = 0;
		endfunction

		function void clear_grid();
			foreach (occ[r])
				occ[r] = '0;
			cursor = 0;
			high_mark = 0;
		endfunction

		function void set_columns(logic [CFG_W-1:0] value);
			column_reg = value;
		endfunction

		function int pending();
			return placements_q.size();
		endfunction

		function bit line_index(logic [KIND_W-1:0] kind, int value, int cols, output int idx);
			int i;
			idx = 0;
			if (kind != KIND_LINE)
				return 0;
			i = (value > 0) ? value - 1 : cols + 1 + value;
			if (i < 0 || i > cols)
				return 0;
			idx = i;
			return 1;
		endfunction

		function logic [MAX_COLUMNS_DEF-1:0] run_mask(int col, int span);
			logic [31:0] m;
			m = ((32'd1 << span) - 32'd1) << col;
			return m[MAX_COLUMNS_DEF-1:0];
		endfunction

		function result_word_t place_item(item_word_t w);
			int cols, raw, span, s, e, start, row, col, cand, end_cell;
			bit has_s, has_e, has_start, ok;
			result_word_t r;
			cols = column_reg;
			if (cols < 1)
				cols = 1;
			if (cols > MAX_COLUMNS_DEF)
				cols = MAX_COLUMNS_DEF;
			if (w.first_item)
				clear_grid();
			raw = 1;
			if (w.start_kind == KIND_SPAN)
				raw = $signed(w.start_value);
			if (w.end_kind == KIND_SPAN)
				raw = $signed(w.end_value);
			if (raw < 0 || raw > cols)
				span = cols;
			else if (raw == 0)
				span = 1;
			else
				span = raw;
			has_s = line_index(w.start_kind, $signed(w.start_value), cols, s);
			has_e = line_index(w.end_kind, $signed(w.end_value), cols, e);
			has_start = has_s || has_e;
			start = 0;
			if (has_s) begin
				start = (s < cols - 1) ? s : cols - 1;
				if (has_e && e > s)
					span = e - s;
				if (span > cols - start)
					span = cols - start;
			end else if (has_e) begin
				start = (e >= span) ? e - span : 0;
				if (start > cols - span)
					start = cols - span;
			end
			ok = 0;
			row = 0;
			col = start;
			if (has_start) begin
				for (row = 0; row < MAX_ROWS_DEF; row++) begin
					if ((occ[row] & run_mask(col, span)) == '0) begin
						ok = 1;
						break;
					end
				end
			end else begin
				cand = cursor;
				while (!ok) begin
					row = cand / cols;
					col = cand % cols;
					if (row >= MAX_ROWS_DEF)
						break;
					if (col + span <= cols && (occ[row] & run_mask(col, span)) == '0)
						ok = 1;
					else
						cand++;
				end
			end
			if (ok) begin
				occ[row] = occ[row] | run_mask(col, span);
				end_cell = row * cols + col + span;
				if (!has_start)
					cursor = end_cell;
				if (end_cell > high_mark)
					high_mark = end_cell;
			end else begin
				row = 0;
				col = 0;
			end
			r.row = row[ROW_OW-1:0];
			r.column = col[COL_OW-1:0];
			r.span = span[SPAN_OW-1:0];
			r.cells_used = high_mark[CELL_OW-1:0];
			r.overflow = !ok;
			return r;
		endfunction

		function void note_item(item_word_t w);
			placements_q = {placements_q, place_item(w)};
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_field(string name, int got, int want);
			if (got != want)
				report($sformatf("result %0d: %s is %0d, expected %0d", checked, name, got,
					want));
		endtask

		task check_result(result_word_t got);
			result_word_t want;
			if (placements_q.size() == 0) begin
				report($sformatf("result word with no item waiting: row %0d column %0d",
					got.row, got.column));
				return;
			end
			want = placements_q.pop_front();
			check_field("row", got.row, want.row);
			check_field("column", got.column, want.column);
			check_field("span", got.span, want.span);
			check_field("cells_used", got.cells_used, want.cells_used);
			check_field("overflow", got.overflow, want.overflow);
			if (want.overflow)
				overflows++;
			checked++;
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	logic             take_result = 1'b0;
	bit               calm = 1'b0;
	int               items_sent = 0;
	int               settings_used = 0;
	placement_board   board = new();

	gia_item_if   item_bus ();
	gia_result_if result_bus ();

	assign result_bus.ready = take_result;

	grid_item_auto_placement i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item       (item_bus),
		.result     (result_bus)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			take_result <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready)
				board.check_result({result_bus.row, result_bus.column, result_bus.span,
					result_bus.cells_used, result_bus.overflow});
			take_result <= calm || ($urandom_range(99) >= 24);
		end
	end

	function automatic item_word_t item_of(bit first, logic [KIND_W-1:0] sk, int sv,
		logic [KIND_W-1:0] ek, int ev);
		item_word_t w;
		w.first_item = first;
		w.start_kind = sk;
		w.start_value = sv[VAL_W-1:0];
		w.end_kind = ek;
		w.end_value = ev[VAL_W-1:0];
		return w;
	endfunction

	function automatic int random_value();
		if ($urandom_range(9) < 7)
			return int'($urandom_range(40)) - 20;
		return int'($urandom_range(255));
	endfunction

	function automatic item_word_t random_item(bit first, bit wide);
		if (wide && $urandom_range(1) == 1)
			return item_of(first, KIND_AUTO, 0, KIND_SPAN, MAX_COLUMNS_DEF);
		return item_of(first, 2'($urandom_range(3)), random_value(),
			2'($urandom_range(3)), random_value());
	endfunction

	task automatic send_item(item_word_t w);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 24)
				gap++;
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.first_item <= w.first_item;
		item_bus.start_kind <= w.start_kind;
		item_bus.start_value <= w.start_value;
		item_bus.end_kind <= w.end_kind;
		item_bus.end_value <= w.end_value;
		do @(posedge clk); while (!item_bus.ready);
		board.note_item(w);
		items_sent++;
	endtask

	task automatic wait_idle();
		item_bus.valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic write_columns(logic [CFG_W-1:0] value);
		wait_idle();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_columns(value);
		settings_used++;
	endtask

	initial begin
		logic [CFG_W-1:0] phase_cols [6];
		bit first, wide;
		int odds;
		item_bus.valid = 1'b0;
		item_bus.first_item = 1'b0;
		item_bus.start_kind = KIND_AUTO;
		item_bus.start_value = '0;
		item_bus.end_kind = KIND_AUTO;
		item_bus.end_value = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_columns(5'd4);
		send_item(item_of(1, KIND_AUTO, 0, KIND_AUTO, 0));
		send_item(item_of(0, KIND_LINE, 1, KIND_LINE, 5));
		send_item(item_of(0, KIND_LINE, -1, KIND_AUTO, 0));
		send_item(item_of(0, KIND_LINE, 0, KIND_SPAN, 3));
		send_item(item_of(0, KIND_SPAN, 0, KIND_AUTO, 0));
		send_item(item_of(0, KIND_SPAN, -3, KIND_AUTO, 0));
		send_item(item_of(0, KIND_SPAN, 2, KIND_SPAN, 3));
		send_item(item_of(0, KIND_AUTO, 0, KIND_LINE, 3));
		send_item(item_of(0, KIND_SPAN, 3, KIND_LINE, 2));
		send_item(item_of(0, KIND_LINE, -5, KIND_AUTO, 0));
		send_item(item_of(0, KIND_LINE, 3, KIND_LINE, 2));
		send_item(item_of(0, KIND_LINE, 127, KIND_LINE, -128));
		send_item(item_of(0, KIND_RESERVED, 5, KIND_RESERVED, -2));
		send_item(item_of(0, KIND_LINE, 5, KIND_LINE, 5));
		send_item(item_of(0, KIND_LINE, -6, KIND_SPAN, 64));
		write_columns(5'd0);
		send_item(item_of(1, KIND_AUTO, 0, KIND_SPAN, 2));
		send_item(item_of(0, KIND_LINE, 1, KIND_LINE, 2));
		write_columns(5'd31);
		send_item(item_of(1, KIND_LINE, 2, KIND_LINE, -1));
		send_item(item_of(0, KIND_AUTO, 0, KIND_SPAN, 16));
		write_columns(5'd16);
		for (int i = 0; i < 5; i++)
			send_item(item_of(i == 0, KIND_AUTO, 0, KIND_SPAN, 16));
		write_columns(5'd1);
		send_item(item_of(0, KIND_AUTO, 0, KIND_AUTO, 0));
		send_item(item_of(0, KIND_LINE, 1, KIND_AUTO, 0));

		phase_cols[0] = 5'd1;
		phase_cols[1] = 5'd16;
		phase_cols[2] = 5'd2;
		phase_cols[3] = 5'($urandom_range(31));
		phase_cols[4] = 5'd3;
		phase_cols[5] = 5'($urandom_range(31));
		for (int p = 0; p < 6; p++) begin
			write_columns(phase_cols[p]);
			calm = (p == 2);
			wide = (p == 1);
			odds = (p < 2) ? 0 : 30;
			for (int i = 0; i < 75; i++) begin
				if (i == 35)
					wait_idle();
				first = (i == 0) || (odds > 0 && $urandom_range(odds - 1) == 0);
				send_item(random_item(first, wide));
			end
		end
		calm = 1'b0;

		wait_idle();
		repeat (300) @(posedge clk);
		if (board.pending() != 0)
			board.report($sformatf("%0d placements never returned", board.pending()));
		$display("Placed %0d items under %0d column settings; %0d results checked.",
			items_sent, settings_used, board.checked);
		$display("%0d results reported overflow, %0d mismatches found.",
			board.overflows, board.errors);
		if (board.errors == 0)
			$display("grid_item_auto_placement test passed");
		else
			$display("grid_item_auto_placement test failed");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("grid_item_auto_placement test failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/gia_pkg.sv
design/gia_item_if.sv
design/gia_result_if.sv
design/gia_ram.sv
design/gia_ctrl.sv
design/gia_dp.sv
design/grid_item_auto_placement.sv
test/grid_item_auto_placement_tb.sv
